// ===== rtl/core/uart_bootloader_flash_host_defines.svh =====
// Assertion macros shared by the bootloader host RTL.
// No dependencies; included by the modules that carry checks.
`ifndef UART_BOOTLOADER_FLASH_HOST_DEFINES_SVH
`define UART_BOOTLOADER_FLASH_HOST_DEFINES_SVH

`ifndef SYNTHESIS
`define UBFH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ubfh check failed");
`define UBFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ubfh check failed");
`else
`define UBFH_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define UBFH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/ubfh_pkg.sv =====
`timescale 1ns / 1ps
// Types, protocol bytes and register codes of the bootloader host.
// No dependencies; imported by every module of the block.
package ubfh_pkg;

    localparam int MAX_IMAGE_BYTES_DEF = 131072;
    localparam int CHUNK_BYTES_DEF     = 256;

    localparam int TX_MAX      = 5;
    localparam int TXN_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_IMAGE = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [2:0] ST_IDLE         = 3'd0;
    localparam logic [2:0] ST_BUSY         = 3'd1;
    localparam logic [2:0] ST_SUCCESS      = 3'd2;
    localparam logic [2:0] ST_SYNC_FAILED  = 3'd3;
    localparam logic [2:0] ST_ERASE_FAILED = 3'd4;
    localparam logic [2:0] ST_WRITE_FAILED = 3'd5;

    localparam logic [2:0] REG_IMAGE_LENGTH  = 3'd0;
    localparam logic [2:0] REG_FLASH_BASE    = 3'd1;
    localparam logic [2:0] REG_SYNC_TIMEOUT  = 3'd2;
    localparam logic [2:0] REG_SYNC_RETRIES  = 3'd3;
    localparam logic [2:0] REG_ACK_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_ERASE_TIMEOUT = 3'd5;
    localparam logic [2:0] REG_WRITE_TIMEOUT = 3'd6;

    localparam logic [17:0] IMAGE_LENGTH_RST  = 18'd1;
    localparam logic [31:0] FLASH_BASE_RST    = 32'h0800_0000;
    localparam logic [15:0] SYNC_TIMEOUT_RST  = 16'd500;
    localparam logic [3:0]  SYNC_RETRIES_RST  = 4'd10;
    localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd2000;
    localparam logic [15:0] ERASE_TIMEOUT_RST = 16'd30000;
    localparam logic [15:0] WRITE_TIMEOUT_RST = 16'd5000;

    localparam logic [7:0] B_SYNC  = 8'h7F;
    localparam logic [7:0] B_ACK   = 8'h79;
    localparam logic [7:0] B_NACK  = 8'h1F;
    localparam logic [7:0] B_ERASE = 8'h44;
    localparam logic [7:0] B_WRITE = 8'h31;
    localparam logic [7:0] B_GO    = 8'h21;
    localparam logic [7:0] B_ALL   = 8'hFF;

    typedef struct packed {
        logic [TX_MAX-1:0][7:0] tx_bytes;
        logic [TXN_W-1:0]       tx_count;
        logic                   want;
        logic [2:0]             status;
        logic [17:0]            bytes_written;
    } job_t;

endpackage

// ===== rtl/core/uart_bootloader_flash_host.sv =====
`timescale 1ns / 1ps
// Bootloader host: one item accepted per cycle while the two-entry job queue has room.
// The first result of an item is registered in the job queue and then in the serialiser's
// current-job register; it leaves without waiting when the queue and the serialiser are empty.
// Output: an item yields one to five results, one per cycle from the output serialiser while
// out_stall is low; the serialiser sets the sustained rate.
// Reset: asynchronous, clears the sequencer, the queue and restores register defaults.
module uart_bootloader_flash_host
    import ubfh_pkg::*;
#(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF,
    parameter int CHUNK_BYTES     = CHUNK_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        want_image_byte,
    output logic [2:0]  status,
    output logic [17:0] bytes_written,
    output logic        last
);

    logic q_full;
    logic q_push;
    job_t q_job;
    logic q_pop;
    logic q_not_empty;
    job_t q_head;

    ubfh_front #(
        .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
        .CHUNK_BYTES     (CHUNK_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .data_byte (data_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    ubfh_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ubfh_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tx_byte         (tx_byte),
        .tx_valid        (tx_valid),
        .want_image_byte (want_image_byte),
        .status          (status),
        .bytes_written   (bytes_written),
        .last            (last)
    );

endmodule

// ===== rtl/core/ubfh_front.sv =====
`timescale 1ns / 1ps
// Front end: configuration registers, session sequencer and transfer builder.
// Depends on ubfh_pkg; feeds one job per accepted item into ubfh_queue.
module ubfh_front
    import ubfh_pkg::*;
#(
    parameter int MAX_IMAGE_BYTES = MAX_IMAGE_BYTES_DEF,
    parameter int CHUNK_BYTES     = CHUNK_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  data_byte,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        q_full,
    output logic        q_push,
    output job_t        q_job
);

    localparam int OFF_W = $clog2(MAX_IMAGE_BYTES + 1);
    localparam int CL_W  = $clog2(CHUNK_BYTES + 1);
    localparam int CMP_W = (OFF_W > 18) ? OFF_W : 18;

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_SYNC       = 4'd1;
    localparam logic [3:0] PH_ERASE_CMD  = 4'd2;
    localparam logic [3:0] PH_ERASE_WAIT = 4'd3;
    localparam logic [3:0] PH_WR_CMD     = 4'd4;
    localparam logic [3:0] PH_WR_ADDR    = 4'd5;
    localparam logic [3:0] PH_WR_DATA    = 4'd6;
    localparam logic [3:0] PH_WR_ACK     = 4'd7;
    localparam logic [3:0] PH_GO_CMD     = 4'd8;
    localparam logic [3:0] PH_GO_ADDR    = 4'd9;

    logic [17:0] image_length_reg;
    logic [31:0] flash_base_reg;
    logic [15:0] sync_timeout_reg;
    logic [3:0]  sync_retries_reg;
    logic [15:0] ack_timeout_reg;
    logic [15:0] erase_timeout_reg;
    logic [15:0] write_timeout_reg;

    logic [3:0]       phase_reg, phase_next;
    logic [15:0]      timer_reg, timer_next;
    logic [3:0]       attempt_reg, attempt_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [CL_W-1:0]  chunk_left_reg, chunk_left_next;
    logic [7:0]       xor_reg, xor_next;
    logic [2:0]       final_reg, final_next;
    logic [OFF_W-1:0] len_reg, len_next;
    logic [31:0]      base_reg, base_next;

    logic             accept;
    logic             fail_hit;
    logic [2:0]       fail_status;
    logic [CMP_W-1:0] len_wide;
    logic [OFF_W-1:0] len_cap;
    logic [OFF_W-1:0] rem;
    logic [OFF_W-1:0] chunk_w;
    logic [OFF_W-1:0] offset_after;
    logic             more_now;
    logic             more_after;
    logic [7:0]       len_byte;
    logic [31:0]      wr_addr;
    logic [15:0]      timer_inc;
    logic [15:0]      tmo;
    logic             expired;
    logic [7:0]       xor_data;

    function automatic logic [TX_MAX-1:0][7:0] addr_bytes(input logic [31:0] a);
        logic [TX_MAX-1:0][7:0] b;
        b[0] = a[31:24];
        b[1] = a[23:16];
        b[2] = a[15:8];
        b[3] = a[7:0];
        b[4] = a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
        return b;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;

    assign len_wide = CMP_W'(image_length_reg);
    assign len_cap  = (len_wide > CMP_W'(MAX_IMAGE_BYTES)) ? OFF_W'(MAX_IMAGE_BYTES)
                                                            : OFF_W'(len_wide);

    assign more_now = offset_reg < len_reg;
    assign rem      = more_now ? (len_reg - offset_reg) : '0;

    always_comb
    begin
        if (rem > OFF_W'(CHUNK_BYTES))
            chunk_w = OFF_W'(CHUNK_BYTES);
        else if (rem == '0)
            chunk_w = OFF_W'(1);
        else
            chunk_w = rem;
    end

    assign len_byte     = 8'(chunk_w - OFF_W'(1));
    assign offset_after = offset_reg + chunk_w;
    assign more_after   = offset_after < len_reg;
    assign wr_addr      = base_reg + 32'(offset_reg);
    assign timer_inc    = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
    assign xor_data     = xor_reg ^ data_byte;

    always_comb
    begin
        unique case (phase_reg)
            PH_SYNC:       tmo = sync_timeout_reg;
            PH_ERASE_WAIT: tmo = erase_timeout_reg;
            PH_WR_ACK:     tmo = write_timeout_reg;
            default:       tmo = ack_timeout_reg;
        endcase
    end

    assign expired = timer_inc >= tmo;

    always_comb
    begin
        unique case (phase_reg) inside
            PH_ERASE_CMD, PH_ERASE_WAIT:                   fail_status = ST_ERASE_FAILED;
            PH_WR_CMD, PH_WR_ADDR, PH_WR_DATA, PH_WR_ACK:  fail_status = ST_WRITE_FAILED;
            default:                                       fail_status = ST_SUCCESS;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        attempt_next    = attempt_reg;
        offset_next     = offset_reg;
        chunk_left_next = chunk_left_reg;
        xor_next        = xor_reg;
        final_next      = final_reg;
        len_next        = len_reg;
        base_next       = base_reg;
        fail_hit        = 1'b0;
        q_job           = '0;

        if (accept)
        begin
            unique case (cmd)
                CMD_START:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        len_next          = len_cap;
                        base_next         = flash_base_reg;
                        offset_next       = '0;
                        chunk_left_next   = '0;
                        xor_next          = '0;
                        attempt_next      = 4'd1;
                        timer_next        = '0;
                        q_job.tx_bytes[0] = B_SYNC;
                        q_job.tx_count    = TXN_W'(1);
                        phase_next        = PH_SYNC;
                    end
                end
                CMD_IMAGE:
                begin
                    if (phase_reg == PH_WR_DATA && chunk_left_reg != '0)
                    begin
                        q_job.tx_bytes[0] = data_byte;
                        xor_next          = xor_data;
                        chunk_left_next   = chunk_left_reg - CL_W'(1);
                        if (chunk_left_reg == CL_W'(1))
                        begin
                            q_job.tx_bytes[1] = xor_data;
                            q_job.tx_count    = TXN_W'(2);
                            timer_next        = '0;
                            phase_next        = PH_WR_ACK;
                        end
                        else
                        begin
                            q_job.tx_count = TXN_W'(1);
                        end
                    end
                end
                CMD_RX:
                begin
                    if (phase_reg != PH_IDLE && phase_reg != PH_WR_DATA)
                    begin
                        if (data_byte == B_ACK)
                        begin
                            timer_next = '0;
                            unique case (phase_reg)
                                PH_SYNC:
                                begin
                                    q_job.tx_bytes[0] = B_ERASE;
                                    q_job.tx_bytes[1] = ~B_ERASE;
                                    q_job.tx_count    = TXN_W'(2);
                                    phase_next        = PH_ERASE_CMD;
                                end
                                PH_ERASE_CMD:
                                begin
                                    q_job.tx_bytes[0] = B_ALL;
                                    q_job.tx_bytes[1] = B_ALL;
                                    q_job.tx_bytes[2] = 8'h00;
                                    q_job.tx_count    = TXN_W'(3);
                                    phase_next        = PH_ERASE_WAIT;
                                end
                                PH_ERASE_WAIT, PH_WR_ACK:
                                begin
                                    if (phase_reg == PH_WR_ACK)
                                        offset_next = offset_after;
                                    q_job.tx_count = TXN_W'(2);
                                    if ((phase_reg == PH_WR_ACK) ? more_after : more_now)
                                    begin
                                        q_job.tx_bytes[0] = B_WRITE;
                                        q_job.tx_bytes[1] = ~B_WRITE;
                                        phase_next        = PH_WR_CMD;
                                    end
                                    else
                                    begin
                                        q_job.tx_bytes[0] = B_GO;
                                        q_job.tx_bytes[1] = ~B_GO;
                                        phase_next        = PH_GO_CMD;
                                    end
                                end
                                PH_WR_CMD:
                                begin
                                    q_job.tx_bytes = addr_bytes(wr_addr);
                                    q_job.tx_count = TXN_W'(TX_MAX);
                                    phase_next     = PH_WR_ADDR;
                                end
                                PH_WR_ADDR:
                                begin
                                    chunk_left_next   = CL_W'(chunk_w);
                                    xor_next          = len_byte;
                                    q_job.tx_bytes[0] = len_byte;
                                    q_job.tx_count    = TXN_W'(1);
                                    phase_next        = PH_WR_DATA;
                                end
                                PH_GO_CMD:
                                begin
                                    q_job.tx_bytes = addr_bytes(base_reg);
                                    q_job.tx_count = TXN_W'(TX_MAX);
                                    phase_next     = PH_GO_ADDR;
                                end
                                PH_GO_ADDR:
                                begin
                                    phase_next      = PH_IDLE;
                                    final_next      = ST_SUCCESS;
                                    chunk_left_next = '0;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        else if (data_byte == B_NACK && phase_reg != PH_SYNC)
                        begin
                            fail_hit = 1'b1;
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (phase_reg != PH_IDLE && phase_reg != PH_WR_DATA)
                    begin
                        timer_next = timer_inc;
                        if (expired)
                        begin
                            if (phase_reg == PH_SYNC)
                            begin
                                if (attempt_reg < sync_retries_reg)
                                begin
                                    attempt_next      = attempt_reg + 4'd1;
                                    timer_next        = '0;
                                    q_job.tx_bytes[0] = B_SYNC;
                                    q_job.tx_count    = TXN_W'(1);
                                end
                                else
                                begin
                                    phase_next      = PH_IDLE;
                                    final_next      = ST_SYNC_FAILED;
                                    chunk_left_next = '0;
                                end
                            end
                            else
                            begin
                                fail_hit = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (fail_hit)
            begin
                phase_next      = PH_IDLE;
                final_next      = fail_status;
                chunk_left_next = '0;
            end
        end

        q_job.want          = (phase_next == PH_WR_DATA) && (chunk_left_next != '0);
        q_job.status        = (phase_next != PH_IDLE) ? ST_BUSY : final_next;
        q_job.bytes_written = 18'(CMP_W'(offset_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg  <= IMAGE_LENGTH_RST;
            flash_base_reg    <= FLASH_BASE_RST;
            sync_timeout_reg  <= SYNC_TIMEOUT_RST;
            sync_retries_reg  <= SYNC_RETRIES_RST;
            ack_timeout_reg   <= ACK_TIMEOUT_RST;
            erase_timeout_reg <= ERASE_TIMEOUT_RST;
            write_timeout_reg <= WRITE_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_LENGTH:  image_length_reg  <= cfg_data[17:0];
                REG_FLASH_BASE:    flash_base_reg    <= cfg_data;
                REG_SYNC_TIMEOUT:  sync_timeout_reg  <= cfg_data[15:0];
                REG_SYNC_RETRIES:  sync_retries_reg  <= cfg_data[3:0];
                REG_ACK_TIMEOUT:   ack_timeout_reg   <= cfg_data[15:0];
                REG_ERASE_TIMEOUT: erase_timeout_reg <= cfg_data[15:0];
                REG_WRITE_TIMEOUT: write_timeout_reg <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            attempt_reg    <= '0;
            offset_reg     <= '0;
            chunk_left_reg <= '0;
            xor_reg        <= '0;
            final_reg      <= ST_IDLE;
            len_reg        <= '0;
            base_reg       <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            timer_reg      <= timer_next;
            attempt_reg    <= attempt_next;
            offset_reg     <= offset_next;
            chunk_left_reg <= chunk_left_next;
            xor_reg        <= xor_next;
            final_reg      <= final_next;
            len_reg        <= len_next;
            base_reg       <= base_next;
        end
    end

endmodule

// ===== rtl/core/ubfh_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between the sequencer and the result serialiser.
// Depends on ubfh_pkg and the assertion macro header.
`include "uart_bootloader_flash_host_defines.svh"
module ubfh_queue
    import ubfh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            if (push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    `UBFH_ASSERT_SAME(a_no_push_when_full, clk, rst_n, push, !full || do_pop)
    `UBFH_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))

endmodule

// ===== rtl/core/ubfh_back.sv =====
`timescale 1ns / 1ps
// Back end: takes jobs off the queue and presents one result per transfer.
// Depends on ubfh_pkg and the assertion macro header.
`include "uart_bootloader_flash_host_defines.svh"
module ubfh_back
    import ubfh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_not_empty,
    input  job_t        q_head,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  tx_byte,
    output logic        tx_valid,
    output logic        want_image_byte,
    output logic [2:0]  status,
    output logic [17:0] bytes_written,
    output logic        last
);

    logic             cur_valid_reg;
    job_t             cur_reg;
    logic [TXN_W-1:0] k_reg;
    logic [TXN_W-1:0] last_k;
    logic             xfer;

    assign last_k = (cur_reg.tx_count == '0) ? '0 : cur_reg.tx_count - TXN_W'(1);
    assign xfer   = cur_valid_reg && !out_stall;
    assign last   = k_reg == last_k;
    assign q_pop  = q_not_empty && (!cur_valid_reg || (xfer && last));

    assign out_valid       = cur_valid_reg;
    assign tx_valid        = cur_reg.tx_count != '0;
    assign tx_byte         = tx_valid ? cur_reg.tx_bytes[k_reg] : 8'h00;
    assign want_image_byte = cur_reg.want;
    assign status          = cur_reg.status;
    assign bytes_written   = cur_reg.bytes_written;

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else if (q_pop)
        begin
            cur_valid_reg <= 1'b1;
            k_reg         <= '0;
        end
        else if (xfer)
        begin
            if (last)
                cur_valid_reg <= 1'b0;
            else
                k_reg <= k_reg + TXN_W'(1);
        end
    end

    `UBFH_ASSERT_SAME(a_index_in_job, clk, rst_n, cur_valid_reg, k_reg <= last_k)
    `UBFH_ASSERT_NEXT(a_job_continues, clk, rst_n, xfer && !last, out_valid)

endmodule
